@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the floor span extractor.
// No dependencies; each module that asserts includes this header itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define FSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("floor span extractor check failed");

// Clocked check that also holds during reset.
`define FSE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("floor span extractor check failed");

`endif

@@ src/fse_pkg.sv @@
// Package of the floor span extractor: transfer payload types and fixed constants.
// No dependencies; used by every module of the block.
`default_nettype none

package fse_pkg;

  // Field widths of the transfers and of the configuration register.
  localparam int unsigned WallHeightW = 16;
  localparam int unsigned ColumnW     = 9;
  localparam int unsigned RowW        = 6;
  localparam int unsigned HalfW       = 7;

  // Reset value of the half height register.
  localparam logic [HalfW-1:0] HalfHeightReset = 7'd64;

  // Wall height units per row are eight, so the row count drops the low bits.
  localparam int unsigned RowShift = 3;

  typedef struct packed {
    logic [WallHeightW-1:0] wall_height;
    logic                   last_column;
  } in_item_t;

  typedef struct packed {
    logic [ColumnW-1:0] span_start;
    logic [ColumnW-1:0] span_end;
    logic [RowW-1:0]    span_row;
    logic               last_of_run;
  } out_item_t;

  // Shift control handed down the chain of start column cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

`default_nettype wire

@@ src/fse_cell.sv @@
// One cell of the start column chain: holds the start column of one open row.
// Depends on fse_pkg for the shift control struct.
`default_nettype none

module fse_cell #(
  parameter int unsigned WIDTH = 9
) (
  input  wire logic                clk_i,
  input  wire fse_pkg::stack_ctrl_t ctrl_i,
  input  wire logic [WIDTH-1:0]    above_i,
  input  wire logic [WIDTH-1:0]    below_i,
  output logic      [WIDTH-1:0]    value_o
);

  logic [WIDTH-1:0] value_q;

  // A push takes the neighbour above, a pop the neighbour below.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      value_q <= above_i;
    end else if (ctrl_i.pop) begin
      value_q <= below_i;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ src/fse_stack.sv @@
// Chain of start column cells forming a stack; the first cell is the lowest open row.
// Depends on fse_pkg and fse_cell.
`default_nettype none

module fse_stack #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 9
) (
  input  wire logic                 clk_i,
  input  wire fse_pkg::stack_ctrl_t ctrl_i,
  input  wire logic [WIDTH-1:0]     push_data_i,
  output logic      [WIDTH-1:0]     top_o
);

  logic [WIDTH-1:0] value [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIDTH-1:0] above;
    logic [WIDTH-1:0] below;

    if (k == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_inner_above
      assign above = value[k-1];
    end

    // The deepest cell refills with its own value on a pop.
    if (k == DEPTH - 1) begin : g_last
      assign below = value[k];
    end else begin : g_inner_below
      assign below = value[k+1];
    end

    fse_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .above_i (above),
      .below_i (below),
      .value_o (value[k])
    );
  end

  assign top_o = value[0];

endmodule

`default_nettype wire

@@ src/floor_span_extractor.sv @@
// Floor span extractor: one column per input transfer, several spans out. A column is accepted
// in the idle state, then the sequencer opens or closes its rows one at a time, then a closing
// step returns to idle; flushed rows on the last column and any output stall lengthen the work.
// The row sequencer moves one row a cycle through the cell chain unless an output stall holds it.
// Reset: half height 64, current height min(64, MAX_HALF_ROWS), column 0, no result pending;
// the start column cells are not cleared and hold nothing defined until pushed.
`default_nettype none
`include "assert_macros.svh"

module floor_span_extractor #(
  parameter int unsigned MAX_HALF_ROWS = 64,
  parameter int unsigned MAX_COLUMNS   = 512
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Column input
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fse_pkg::in_item_t               in_data_i,
  // Span output
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fse_pkg::out_item_t                   out_data_o,
  // Half height register
  input  wire logic                            cfg_we_i,
  input  wire logic [fse_pkg::HalfW-1:0]       cfg_wdata_i
);

  // Height counter must hold MAX_HALF_ROWS itself; column counter indexes columns.
  localparam int unsigned LW = $clog2(MAX_HALF_ROWS + 1);
  localparam int unsigned XW = $clog2(MAX_COLUMNS);
  localparam int unsigned HW = fse_pkg::WallHeightW - fse_pkg::RowShift;

  localparam logic [LW-1:0] MaxRows  = LW'(MAX_HALF_ROWS);
  localparam logic [XW-1:0] LastCol  = XW'(MAX_COLUMNS - 1);
  localparam logic [LW-1:0] ResetL   =
    (fse_pkg::HalfHeightReset > fse_pkg::HalfW'(MAX_HALF_ROWS)) ? MaxRows
                                         : LW'(fse_pkg::HalfHeightReset);

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic                      state_q, state_d;
  logic [fse_pkg::HalfW-1:0] half_q;
  logic [LW-1:0]             cur_height_q, cur_height_d;
  logic [XW-1:0]             column_q, column_d;
  logic [LW-1:0]             target_height_q;
  logic                      last_q;
  // Set once the flush of a last column has begun, so that the rows it closes above the
  // column's own height are not opened again.
  logic                      flush_q;

  logic                      out_valid_q;
  fse_pkg::out_item_t        out_q, out_d;
  logic                      out_load;

  fse_pkg::stack_ctrl_t      stack_ctrl;
  logic [XW-1:0]             stack_top;

  // Effective half height is the register clipped to the number of cells.
  logic [LW-1:0] eff_half;
  logic [LW-1:0] cfg_half;
  assign eff_half = (half_q > fse_pkg::HalfW'(MAX_HALF_ROWS)) ? MaxRows : half_q[LW-1:0];
  assign cfg_half = (cfg_wdata_i > fse_pkg::HalfW'(MAX_HALF_ROWS)) ? MaxRows
                                                                    : cfg_wdata_i[LW-1:0];

  // Row count of the incoming column. Saturating at the cell count changes no decision,
  // since the current height never exceeds it.
  logic [HW-1:0] in_rows;
  logic [LW-1:0] in_rows_sat;
  assign in_rows     = in_data_i.wall_height[fse_pkg::WallHeightW-1:fse_pkg::RowShift];
  assign in_rows_sat = (in_rows > HW'(MAX_HALF_ROWS)) ? MaxRows : in_rows[LW-1:0];

  // Neighbouring columns with wrap-around.
  logic [XW-1:0] prev_column;
  logic [XW-1:0] next_column;
  assign prev_column = (column_q == '0) ? LastCol : column_q - XW'(1);
  assign next_column = (column_q == LastCol) ? '0 : column_q + XW'(1);

  // Per-cycle row decisions while a column is worked on. A fall opens rows from the top
  // of the stack downwards; a rise closes them upwards to the capped target; on the last
  // column the remaining rows up to the half height are flushed with the current column.
  logic [LW-1:0] rise_limit;
  logic          do_fall, do_rise, do_flush, do_pop, do_emit, slot_free, stall, work_done;
  logic [LW-1:0] final_row_next;

  assign rise_limit = (target_height_q < eff_half) ? target_height_q : eff_half;
  assign do_fall    = !flush_q && (cur_height_q > target_height_q);
  assign do_rise    = cur_height_q < rise_limit;
  assign do_flush   = !do_fall && !do_rise && last_q && (cur_height_q < eff_half);
  assign do_pop     = do_rise || do_flush;
  // Row zero is closed like any other but never reported.
  assign do_emit    = do_pop && (cur_height_q != '0);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign stall      = do_emit && !slot_free;
  assign work_done  = !do_fall && !do_pop;

  // The closed rows of one column are contiguous, so the last span is the one whose row
  // sits just below the final height that the column reaches.
  assign final_row_next = last_q ? eff_half : rise_limit;

  always_comb begin
    state_d      = state_q;
    cur_height_d = cur_height_q;
    column_d     = column_q;
    stack_ctrl   = '0;
    out_load     = 1'b0;
    out_d        = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (do_fall) begin
          stack_ctrl.push = 1'b1;
          cur_height_d    = cur_height_q - LW'(1);
        end else if (do_pop && !stall) begin
          stack_ctrl.pop = 1'b1;
          cur_height_d   = cur_height_q + LW'(1);
          out_load       = do_emit;
          out_d.span_start  = fse_pkg::ColumnW'(stack_top);
          out_d.span_end    = fse_pkg::ColumnW'(do_rise ? prev_column : column_q);
          out_d.span_row    = fse_pkg::RowW'(cur_height_q);
          out_d.last_of_run = (cur_height_q + LW'(1)) == final_row_next;
        end else if (work_done) begin
          state_d = ST_IDLE;
          if (last_q) begin
            cur_height_d = eff_half;
            column_d     = '0;
          end else begin
            column_d = next_column;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The register starts a new frame; the user must write it only while the block is idle (not enforced).
    if (cfg_we_i) begin
      cur_height_d = cfg_half;
      column_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      half_q       <= fse_pkg::HalfHeightReset;
      cur_height_q <= ResetL;
      column_q     <= '0;
      out_valid_q  <= 1'b0;
      flush_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_height_q <= cur_height_d;
      column_q     <= column_d;
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_valid_i && in_ready_o) begin
        flush_q <= 1'b0;
      end else if (stack_ctrl.pop && do_flush) begin
        flush_q <= 1'b1;
      end
    end
  end

  // Column payload and output payload need no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      target_height_q <= in_rows_sat;
      last_q          <= in_data_i.last_column;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Start columns of the open rows; the first cell belongs to the current height.
  fse_stack #(
    .DEPTH (MAX_HALF_ROWS),
    .WIDTH (XW)
  ) u_stack (
    .clk_i       (clk_i),
    .ctrl_i      (stack_ctrl),
    .push_data_i (column_q),
    .top_o       (stack_top)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The current height never climbs above the effective half height.
  `FSE_ASSERT(a_height_bound, cur_height_q <= eff_half)
  // An accepted column is always worked on in the following cycle.
  `FSE_ASSERT(a_accept_to_work, (in_valid_i && in_ready_o) |=> (state_q == ST_WORK))
  // Row zero is never reported.
  `FSE_ASSERT(a_no_row_zero, out_valid_o |-> (out_data_o.span_row != '0))
  // Every falling step lowers the height by exactly one row.
  `FSE_ASSERT(a_fall_step,
              (state_q == ST_WORK && do_fall && !cfg_we_i) |=>
              (cur_height_q == $past(cur_height_q) - LW'(1)))

endmodule

`default_nettype wire
